// File: rtl/osg_pkg.sv
// Package for the obstacle speed governor: types, codes, constants and table generation.
package osg_pkg;

    localparam int ANGLE_STEPS_DEF = 360;
    localparam int RANGE_BITS_DEF  = 12;

    localparam int LEVEL_W = 15;
    localparam int LIDAR_W = 12;
    localparam int DIST_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam int CM_Q14 = 16384;

    // Box edges in cm, already shifted by the 40 cm sensor offset.
    localparam int BOX_HALF_W_CM = 45;
    localparam int FRONT_FAR_CM  = 110;
    localparam int OFFSET_CM     = 40;
    localparam int BACK_FAR_CM   = 30;

    typedef enum logic [1:0] {
        CMD_ULTRA = 2'd0,
        CMD_LIDAR = 2'd1,
        CMD_PARK  = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        SPD_STOP     = 3'd0,
        SPD_WALK     = 3'd1,
        SPD_HALF     = 3'd2,
        SPD_DETECTED = 3'd3,
        SPD_CLEAR    = 3'd4
    } t_speed;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PARK_STOP  = 3'd0,
        CFG_STOP       = 3'd1,
        CFG_SLOW       = 3'd2,
        CFG_FIRST_SLOW = 3'd3,
        CFG_CAREFUL    = 3'd4,
        CFG_LIDAR_MIN  = 3'd5,
        CFG_LIDAR_MAX  = 3'd6
    } t_cfg_idx;

    localparam logic [LEVEL_W-1:0] PARK_STOP_RST  = 15'd15;
    localparam logic [LEVEL_W-1:0] STOP_RST       = 15'd30;
    localparam logic [LEVEL_W-1:0] SLOW_RST       = 15'd50;
    localparam logic [LEVEL_W-1:0] FIRST_SLOW_RST = 15'd70;
    localparam logic [LEVEL_W-1:0] CAREFUL_RST    = 15'd100;
    localparam logic [LIDAR_W-1:0] LIDAR_MIN_RST  = 12'd12;
    localparam logic [LIDAR_W-1:0] LIDAR_MAX_RST  = 12'd1200;

    typedef struct packed {
        t_cmd                     command;
        logic signed [DIST_W-1:0] front_distance;
        logic signed [DIST_W-1:0] rear_distance;
        logic [8:0]               beam_angle;
        logic [LIDAR_W-1:0]       beam_range_cm;
        logic                     beam_valid;
        logic                     scan_end;
        logic                     park_on;
    } t_in_item;

    typedef struct packed {
        t_speed front_speed;
        t_speed rear_speed;
        logic   front_margin;
        logic   rear_margin;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] cos_q14;
        logic signed [15:0] sin_q14;
    } t_trig;

    typedef struct packed {
        logic [LEVEL_W-1:0] park_stop;
        logic [LEVEL_W-1:0] stop;
        logic [LEVEL_W-1:0] slow;
        logic [LEVEL_W-1:0] first_slow;
        logic [LEVEL_W-1:0] careful;
    } t_levels;

    typedef struct packed {
        logic park_mode;
        logic margin_front;
        logic margin_back;
    } t_grade_ctx;

    // One series step: divide by (n+1)(n+2) for sin (odd) or cos terms.
    function automatic logic [63:0] series_div(logic [63:0] v, logic odd, logic [3:0] step);
        logic [63:0] q;
        case (step)
            4'd0:    q = odd ? v / 6   : v / 2;
            4'd1:    q = odd ? v / 20  : v / 12;
            4'd2:    q = odd ? v / 42  : v / 30;
            4'd3:    q = odd ? v / 72  : v / 56;
            4'd4:    q = odd ? v / 110 : v / 90;
            4'd5:    q = odd ? v / 156 : v / 132;
            4'd6:    q = odd ? v / 210 : v / 182;
            4'd7:    q = odd ? v / 272 : v / 240;
            4'd8:    q = odd ? v / 342 : v / 306;
            4'd9:    q = odd ? v / 420 : v / 380;
            4'd10:   q = odd ? v / 506 : v / 462;
            4'd11:   q = odd ? v / 600 : v / 552;
            4'd12:   q = odd ? v / 702 : v / 650;
            4'd13:   q = odd ? v / 812 : v / 756;
            default: q = v;
        endcase
        return q;
    endfunction

    function automatic logic signed [63:0] series_q30(logic [63:0] phi, logic odd);
        logic [63:0]        p2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        p2   = (phi * phi) >> 30;
        term = odd ? phi : ONE_Q30;
        sum  = $signed(term);
        for (int i = 0; i < 14; i++) begin
            term = series_div((term * p2) >> 30, odd, 4'(i));
            if (i % 2 == 1) begin
                sum = sum + $signed(term);
            end else begin
                sum = sum - $signed(term);
            end
        end
        return sum;
    endfunction

    function automatic logic signed [15:0] round_q14(logic signed [63:0] v);
        logic signed [63:0] c;
        logic signed [63:0] r;
        c = v;
        if (c < 0) begin
            c = 0;
        end
        if (c > $signed(ONE_Q30)) begin
            c = $signed(ONE_Q30);
        end
        r = (c + 64'sd32768) >>> 16;
        return r[15:0];
    endfunction

endpackage

// File: rtl/osg_trig_rom.sv
// Cosine/sine lookup table with angle wrap and registered read.
module osg_trig_rom #(
    parameter int ANGLE_STEPS = osg_pkg::ANGLE_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [8:0]    i_angle,
    output osg_pkg::t_trig o_trig
);

    localparam int IDX_W = $clog2(ANGLE_STEPS);
    localparam int REDUCE_STEPS = 511 / ANGLE_STEPS;
    localparam logic [10:0] STEPS_11 = 11'(ANGLE_STEPS);

    osg_pkg::t_trig rom [ANGLE_STEPS];
    osg_pkg::t_trig r_data;
    logic [10:0]    angle_wrap;
    logic [IDX_W-1:0] idx;

    for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_rom
        localparam int U   = 4 * k;
        localparam int QD  = U / ANGLE_STEPS;
        localparam int REM = U % ANGLE_STEPS;
        localparam logic [63:0] PHI = (osg_pkg::PI_HALF_Q30 * 64'(REM)) / 64'(ANGLE_STEPS);
        localparam logic signed [15:0] S = osg_pkg::round_q14(osg_pkg::series_q30(PHI, 1'b1));
        localparam logic signed [15:0] C = osg_pkg::round_q14(osg_pkg::series_q30(PHI, 1'b0));
        localparam logic [1:0] Q2 = 2'(QD);
        localparam logic signed [15:0] CS = (Q2 == 2'd0) ? C : (Q2 == 2'd1) ? -S :
                                            (Q2 == 2'd2) ? -C : S;
        localparam logic signed [15:0] SN = (Q2 == 2'd0) ? S : (Q2 == 2'd1) ? C :
                                            (Q2 == 2'd2) ? -S : -C;
        assign rom[k] = '{cos_q14: CS, sin_q14: SN};
    end

    always_comb begin
        angle_wrap = {2'b00, i_angle};
        for (int i = 0; i < REDUCE_STEPS; i++) begin
            if (angle_wrap >= STEPS_11) begin
                angle_wrap = angle_wrap - STEPS_11;
            end
        end
    end

    assign idx = angle_wrap[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= rom[idx];
        end
    end

    assign o_trig = r_data;

endmodule

// File: rtl/osg_grader.sv
// Speed grading of one side from its distance, mode and margin flags.
module osg_grader (
    input  osg_pkg::t_grade_ctx              i_ctx,
    input  osg_pkg::t_levels                 i_levels,
    input  logic                             i_front,
    input  osg_pkg::t_speed                  i_code,
    input  logic signed [osg_pkg::DIST_W-1:0] i_dist,
    output osg_pkg::t_speed                  o_code,
    output logic                             o_set
);

    logic below_park;
    logic below_stop;
    logic below_slow;
    logic below_first;
    logic below_careful;

    assign below_park    = i_dist < $signed({1'b0, i_levels.park_stop});
    assign below_stop    = i_dist < $signed({1'b0, i_levels.stop});
    assign below_slow    = i_dist < $signed({1'b0, i_levels.slow});
    assign below_first   = i_dist < $signed({1'b0, i_levels.first_slow});
    assign below_careful = i_dist < $signed({1'b0, i_levels.careful});

    always_comb begin
        o_set  = 1'b1;
        o_code = osg_pkg::SPD_CLEAR;
        if (i_ctx.park_mode) begin
            if (below_park) begin
                o_code = osg_pkg::SPD_STOP;
            end else if (i_ctx.margin_back) begin
                o_code = i_front ? i_code : osg_pkg::SPD_STOP;
            end else if (i_ctx.margin_front) begin
                o_code = i_front ? osg_pkg::SPD_STOP : i_code;
            end
        end else if (below_stop) begin
            o_code = osg_pkg::SPD_STOP;
        end else if (below_slow) begin
            o_code = osg_pkg::SPD_WALK;
        end else if (below_first) begin
            o_code = osg_pkg::SPD_HALF;
        end else if (below_careful) begin
            o_code = osg_pkg::SPD_DETECTED;
            o_set  = 1'b0;
        end
    end

endmodule

// File: rtl/obstacle_speed_governor_core.sv
// Obstacle speed governor top level: ultrasonic grading, lidar margin zones, publish.
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_item  (osg_pkg::t_in_item)
//  out     | output    | o_out_valid / i_out_stall| o_out_item (osg_pkg::t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One transaction per cycle while the input is not stalled.
// Stage one registers the transaction and reads the trig table; stage two does the
// range multiply, zone test and grading and loads the output register.
// Reset is synchronous; no clearing pass, the table is constant.
// A held output stalls the input only when the waiting transaction is a tick with a
// result to give.
module obstacle_speed_governor_core #(
    parameter int ANGLE_STEPS = osg_pkg::ANGLE_STEPS_DEF,
    parameter int RANGE_BITS  = osg_pkg::RANGE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  osg_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output osg_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [osg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [osg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PROD_W = RANGE_BITS + 17;
    localparam logic signed [PROD_W-1:0] LIM_X =
        PROD_W'(osg_pkg::BOX_HALF_W_CM * osg_pkg::CM_Q14);
    localparam logic signed [PROD_W-1:0] LIM_FRONT =
        PROD_W'(osg_pkg::FRONT_FAR_CM * osg_pkg::CM_Q14);
    localparam logic signed [PROD_W-1:0] LIM_OFFSET =
        PROD_W'(osg_pkg::OFFSET_CM * osg_pkg::CM_Q14);
    localparam logic signed [PROD_W-1:0] LIM_BACK =
        PROD_W'(osg_pkg::BACK_FAR_CM * osg_pkg::CM_Q14);

    osg_pkg::t_levels                   r_levels;
    logic [osg_pkg::LIDAR_W-1:0]        r_lidar_min;
    logic [osg_pkg::LIDAR_W-1:0]        r_lidar_max;

    logic               r_park_mode;
    osg_pkg::t_speed    r_front_code;
    osg_pkg::t_speed    r_rear_code;
    logic               r_pending;
    logic               r_margin_front;
    logic               r_margin_back;
    logic               r_scan_front;
    logic               r_scan_back;

    logic               r_s1_valid;
    osg_pkg::t_in_item  r_s1_item;
    osg_pkg::t_trig     s1_trig;

    logic               r_out_valid;
    osg_pkg::t_out_item r_out_item;

    logic               in_accept;
    logic               out_free;
    logic               is_tick;
    logic               emit;
    logic               exec;

    osg_pkg::t_grade_ctx grade_ctx;
    osg_pkg::t_speed     front_grade;
    osg_pkg::t_speed     rear_grade;
    logic                front_set;
    logic                rear_set;

    logic [15:0]                range_ext;
    logic [RANGE_BITS-1:0]      range_cm;
    logic [15:0]                range_16;
    logic                       in_window;
    logic signed [PROD_W-1:0]   prod_cos;
    logic signed [PROD_W-1:0]   prod_sin;
    logic                       x_in;
    logic                       hit_front;
    logic                       hit_back;

    logic               n_pending;
    logic               n_margin_front;
    logic               n_margin_back;
    logic               n_scan_front;
    logic               n_scan_back;

    assign o_cfg_ready = 1'b1;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign is_tick    = r_s1_item.command == osg_pkg::CMD_TICK;
    assign emit       = r_s1_valid && is_tick && r_pending;
    assign exec       = r_s1_valid && (out_free || !(is_tick && r_pending));
    assign o_in_stall = r_s1_valid && !exec;
    assign in_accept  = i_in_valid && !o_in_stall;

    osg_trig_rom #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_trig_rom (
        .i_clk   (i_clk),
        .i_en    (in_accept),
        .i_angle (i_in_item.beam_angle),
        .o_trig  (s1_trig)
    );

    assign grade_ctx = '{park_mode:    r_park_mode,
                         margin_front: r_margin_front,
                         margin_back:  r_margin_back};

    osg_grader u_grade_front (
        .i_ctx    (grade_ctx),
        .i_levels (r_levels),
        .i_front  (1'b1),
        .i_code   (r_front_code),
        .i_dist   (r_s1_item.front_distance),
        .o_code   (front_grade),
        .o_set    (front_set)
    );

    osg_grader u_grade_rear (
        .i_ctx    (grade_ctx),
        .i_levels (r_levels),
        .i_front  (1'b0),
        .i_code   (r_rear_code),
        .i_dist   (r_s1_item.rear_distance),
        .o_code   (rear_grade),
        .o_set    (rear_set)
    );

    // Lidar zone test; x = -r*cos, y = -r*sin - offset, compared at Q14 scale.
    assign range_ext = 16'(r_s1_item.beam_range_cm);
    assign range_cm  = range_ext[RANGE_BITS-1:0];
    assign range_16  = 16'(range_cm);
    assign in_window = r_s1_item.beam_valid
                    && (range_16 > 16'(r_lidar_min))
                    && (range_16 < 16'(r_lidar_max));

    assign prod_cos = PROD_W'($signed({1'b0, range_cm})) * PROD_W'(s1_trig.cos_q14);
    assign prod_sin = PROD_W'($signed({1'b0, range_cm})) * PROD_W'(s1_trig.sin_q14);

    assign x_in      = (prod_cos >= -LIM_X) && (prod_cos <= LIM_X);
    assign hit_front = in_window && x_in && (prod_sin >= -LIM_FRONT)
                    && (prod_sin <= -LIM_OFFSET);
    assign hit_back  = in_window && x_in && (prod_sin >= -LIM_OFFSET)
                    && (prod_sin <= LIM_BACK);

    always_comb begin
        n_pending      = r_pending;
        n_margin_front = r_margin_front;
        n_margin_back  = r_margin_back;
        n_scan_front   = r_scan_front | hit_front;
        n_scan_back    = r_scan_back | hit_back;
        if (r_s1_item.scan_end) begin
            n_margin_front = n_scan_front;
            n_margin_back  = n_scan_back;
            n_scan_front   = 1'b0;
            n_scan_back    = 1'b0;
        end
        if (r_s1_item.command == osg_pkg::CMD_ULTRA) begin
            n_pending = front_set | rear_set;
        end else if (is_tick) begin
            n_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels    <= '{park_stop:  osg_pkg::PARK_STOP_RST,
                             stop:       osg_pkg::STOP_RST,
                             slow:       osg_pkg::SLOW_RST,
                             first_slow: osg_pkg::FIRST_SLOW_RST,
                             careful:    osg_pkg::CAREFUL_RST};
            r_lidar_min <= osg_pkg::LIDAR_MIN_RST;
            r_lidar_max <= osg_pkg::LIDAR_MAX_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (osg_pkg::t_cfg_idx'(i_cfg_index))
                osg_pkg::CFG_PARK_STOP:  r_levels.park_stop  <= i_cfg_data;
                osg_pkg::CFG_STOP:       r_levels.stop       <= i_cfg_data;
                osg_pkg::CFG_SLOW:       r_levels.slow       <= i_cfg_data;
                osg_pkg::CFG_FIRST_SLOW: r_levels.first_slow <= i_cfg_data;
                osg_pkg::CFG_CAREFUL:    r_levels.careful    <= i_cfg_data;
                osg_pkg::CFG_LIDAR_MIN:  r_lidar_min <= i_cfg_data[osg_pkg::LIDAR_W-1:0];
                osg_pkg::CFG_LIDAR_MAX:  r_lidar_max <= i_cfg_data[osg_pkg::LIDAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (exec) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_park_mode    <= 1'b0;
            r_front_code   <= osg_pkg::SPD_CLEAR;
            r_rear_code    <= osg_pkg::SPD_CLEAR;
            r_pending      <= 1'b0;
            r_margin_front <= 1'b0;
            r_margin_back  <= 1'b0;
            r_scan_front   <= 1'b0;
            r_scan_back    <= 1'b0;
        end else if (exec) begin
            r_pending <= n_pending;
            case (r_s1_item.command)
                osg_pkg::CMD_ULTRA: begin
                    r_front_code <= front_grade;
                    r_rear_code  <= rear_grade;
                end
                osg_pkg::CMD_LIDAR: begin
                    r_margin_front <= n_margin_front;
                    r_margin_back  <= n_margin_back;
                    r_scan_front   <= n_scan_front;
                    r_scan_back    <= n_scan_back;
                end
                osg_pkg::CMD_PARK: begin
                    r_park_mode <= r_s1_item.park_on;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec && emit) begin
            r_out_item <= '{front_speed:  r_front_code,
                            rear_speed:   r_rear_code,
                            front_margin: r_margin_front,
                            rear_margin:  r_margin_back};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_tick_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && is_tick |=> !r_pending)
        else $error("pending update survived a tick");

    a_emit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && emit |=> o_out_valid)
        else $error("tick with pending update gave no result");

    a_scan_end_clears_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && r_s1_item.command == osg_pkg::CMD_LIDAR && r_s1_item.scan_end
        |=> !r_scan_front && !r_scan_back)
        else $error("scan hits not cleared at scan end");

    a_stall_needs_blocked_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && is_tick && r_pending && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");
`endif

endmodule

// File: test/testbench.sv
// Self-checking testbench for the obstacle speed governor core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_N = 360;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint CM = 16384;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [osg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct {
        bit                 typed;
        osg_pkg::t_out_item want;
    } t_tag;

    typedef struct {
        osg_pkg::t_in_item  item;
        bit                 typed;
        osg_pkg::t_out_item want;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    osg_pkg::t_in_item              i_in_item = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    osg_pkg::t_out_item             o_out_item;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [osg_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [osg_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    obstacle_speed_governor_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [osg_pkg::LEVEL_W-1:0] lvl_park_stop = 15'd15;
    logic [osg_pkg::LEVEL_W-1:0] lvl_stop = 15'd30;
    logic [osg_pkg::LEVEL_W-1:0] lvl_slow = 15'd50;
    logic [osg_pkg::LEVEL_W-1:0] lvl_first_slow = 15'd70;
    logic [osg_pkg::LEVEL_W-1:0] lvl_careful = 15'd100;
    logic [osg_pkg::LIDAR_W-1:0] lidar_lo = 12'd12;
    logic [osg_pkg::LIDAR_W-1:0] lidar_hi = 12'd1200;
    bit              gov_park = 1'b0;
    osg_pkg::t_speed gov_front = osg_pkg::SPD_CLEAR;
    osg_pkg::t_speed gov_rear = osg_pkg::SPD_CLEAR;
    bit              gov_pending = 1'b0;
    bit              margin_f = 1'b0;
    bit              margin_b = 1'b0;
    bit              hit_f = 1'b0;
    bit              hit_b = 1'b0;
    int              cos_tab[TABLE_N];
    int              sin_tab[TABLE_N];

    osg_pkg::t_out_item due_reports[$];
    t_tag               tag_q[$];
    t_row               rows[$];
    bit                 calm = 1'b0;
    int                 n_errors = 0;
    int                 n_items = 0;
    int                 n_reports = 0;
    int                 n_writes = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint taylor_q30(longint unsigned phi, bit odd);
        longint unsigned p2;
        longint unsigned term;
        longint unsigned n;
        longint          acc;
        p2 = (phi * phi) >> 30;
        term = odd ? phi : (64'd1 << 30);
        n = odd ? 1 : 0;
        acc = longint'(term);
        for (int i = 0; i < 14; i++) begin
            term = ((term * p2) >> 30) / ((n + 1) * (n + 2));
            n += 2;
            if (i % 2 == 1) begin
                acc += longint'(term);
            end else begin
                acc -= longint'(term);
            end
        end
        return acc;
    endfunction

    function automatic int to_q14(longint v);
        longint c;
        c = v;
        if (c < 0) begin
            c = 0;
        end
        if (c > (64'sd1 <<< 30)) begin
            c = 64'sd1 <<< 30;
        end
        return int'((c + 32768) >>> 16);
    endfunction

    initial begin : build_trig
        int unsigned     u;
        int unsigned     q;
        int unsigned     rem;
        longint unsigned phi;
        int              s;
        int              c;
        for (int k = 0; k < TABLE_N; k++) begin
            u = 4 * k;
            q = u / TABLE_N;
            rem = u % TABLE_N;
            phi = (HALF_PI_Q30 * rem) / TABLE_N;
            s = to_q14(taylor_q30(phi, 1'b1));
            c = to_q14(taylor_q30(phi, 1'b0));
            case (q % 4)
                0: begin cos_tab[k] = c;  sin_tab[k] = s;  end
                1: begin cos_tab[k] = -s; sin_tab[k] = c;  end
                2: begin cos_tab[k] = -c; sin_tab[k] = -s; end
                default: begin cos_tab[k] = s; sin_tab[k] = -c; end
            endcase
        end
    end

    function automatic osg_pkg::t_speed grade(osg_pkg::t_speed code, int d, bit front);
        if (gov_park) begin
            gov_pending = 1'b1;
            if (d < int'(lvl_park_stop)) begin
                return osg_pkg::SPD_STOP;
            end
            if (margin_b) begin
                return front ? code : osg_pkg::SPD_STOP;
            end
            if (margin_f) begin
                return front ? osg_pkg::SPD_STOP : code;
            end
            return osg_pkg::SPD_CLEAR;
        end
        if (d < int'(lvl_stop)) begin
            gov_pending = 1'b1;
            return osg_pkg::SPD_STOP;
        end
        if (d < int'(lvl_slow)) begin
            gov_pending = 1'b1;
            return osg_pkg::SPD_WALK;
        end
        if (d < int'(lvl_first_slow)) begin
            gov_pending = 1'b1;
            return osg_pkg::SPD_HALF;
        end
        if (d < int'(lvl_careful)) begin
            return osg_pkg::SPD_DETECTED;
        end
        gov_pending = 1'b1;
        return osg_pkg::SPD_CLEAR;
    endfunction

    task automatic predict_report(input osg_pkg::t_in_item it, output bit has,
                                  output osg_pkg::t_out_item rep);
        int     idx;
        longint r;
        longint x;
        longint y;
        bit     xin;
        has = 1'b0;
        rep = '0;
        case (it.command)
            osg_pkg::CMD_ULTRA: begin
                gov_pending = 1'b0;
                gov_front = grade(gov_front, int'(it.front_distance), 1'b1);
                gov_rear = grade(gov_rear, int'(it.rear_distance), 1'b0);
            end
            osg_pkg::CMD_LIDAR: begin
                idx = int'(it.beam_angle) % TABLE_N;
                r = longint'(it.beam_range_cm);
                if (it.beam_valid && r > longint'(lidar_lo) && r < longint'(lidar_hi)) begin
                    x = -(r * cos_tab[idx]);
                    y = -(r * sin_tab[idx]) - 40 * CM;
                    xin = (x >= -45 * CM) && (x <= 45 * CM);
                    if (xin && y >= 0 && y <= 70 * CM) begin
                        hit_f = 1'b1;
                    end
                    if (xin && y >= -70 * CM && y <= 0) begin
                        hit_b = 1'b1;
                    end
                end
                if (it.scan_end) begin
                    margin_f = hit_f;
                    margin_b = hit_b;
                    hit_f = 1'b0;
                    hit_b = 1'b0;
                end
            end
            osg_pkg::CMD_PARK: gov_park = it.park_on;
            default: begin
                if (gov_pending) begin
                    has = 1'b1;
                    rep.front_speed = gov_front;
                    rep.rear_speed = gov_rear;
                    rep.front_margin = margin_f;
                    rep.rear_margin = margin_b;
                    gov_pending = 1'b0;
                end
            end
        endcase
    endtask

    function automatic void apply_write(logic [osg_pkg::CFG_IDX_W-1:0] idx,
                                        logic [osg_pkg::CFG_DATA_W-1:0] d);
        case (idx)
            osg_pkg::CFG_PARK_STOP:  lvl_park_stop = d;
            osg_pkg::CFG_STOP:       lvl_stop = d;
            osg_pkg::CFG_SLOW:       lvl_slow = d;
            osg_pkg::CFG_FIRST_SLOW: lvl_first_slow = d;
            osg_pkg::CFG_CAREFUL:    lvl_careful = d;
            osg_pkg::CFG_LIDAR_MIN:  lidar_lo = d[osg_pkg::LIDAR_W-1:0];
            osg_pkg::CFG_LIDAR_MAX:  lidar_hi = d[osg_pkg::LIDAR_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_tag               tag;
        bit                 has;
        osg_pkg::t_out_item rep;
        osg_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_write(i_cfg_index, i_cfg_data);
                n_writes++;
            end
            if (i_in_valid && !o_in_stall) begin
                tag = tag_q.pop_front();
                predict_report(i_in_item, has, rep);
                if (tag.typed) begin
                    has = 1'b1;
                    rep = tag.want;
                end
                if (has) begin
                    due_reports.insert(due_reports.size(), rep);
                end
                n_items++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (due_reports.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected report, expected none actual %h", $time,
                             o_out_item);
                end else begin
                    want = due_reports.pop_front();
                    check_field("front_speed", want.front_speed, o_out_item.front_speed);
                    check_field("rear_speed", want.rear_speed, o_out_item.rear_speed);
                    check_field("front_margin", want.front_margin, o_out_item.front_margin);
                    check_field("rear_margin", want.rear_margin, o_out_item.rear_margin);
                    n_reports++;
                end
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < 31);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout with %0d reports outstanding", due_reports.size());
        $display("testbench: done, errors");
        $finish;
    end

    function automatic osg_pkg::t_in_item item_of(osg_pkg::t_cmd c, int fd, int rd, int ang,
                                                  int rng, int bv, int se, int pk);
        osg_pkg::t_in_item it;
        it.command = c;
        it.front_distance = 16'(fd);
        it.rear_distance = 16'(rd);
        it.beam_angle = 9'(ang);
        it.beam_range_cm = 12'(rng);
        it.beam_valid = 1'(bv);
        it.scan_end = 1'(se);
        it.park_on = 1'(pk);
        return it;
    endfunction

    function automatic osg_pkg::t_in_item tick_item();
        return item_of(osg_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    endfunction

    function automatic osg_pkg::t_out_item want_of(osg_pkg::t_speed fs, osg_pkg::t_speed rs,
                                                   int fm, int rm);
        osg_pkg::t_out_item w;
        w.front_speed = fs;
        w.rear_speed = rs;
        w.front_margin = 1'(fm);
        w.rear_margin = 1'(rm);
        return w;
    endfunction

    function automatic void add_row(osg_pkg::t_in_item it, int typed,
                                    osg_pkg::t_out_item want);
        t_row r;
        r.item = it;
        r.typed = 1'(typed);
        r.want = want;
        rows.insert(rows.size(), r);
    endfunction

    function automatic int near_level();
        int lv;
        case ($urandom_range(0, 5))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: lv = int'(lvl_park_stop);
            2: lv = int'(lvl_stop);
            3: lv = int'(lvl_slow);
            4: lv = int'(lvl_first_slow);
            default: lv = int'(lvl_careful);
        endcase
        return lv + int'($urandom_range(0, 4)) - 2;
    endfunction

    function automatic osg_pkg::t_in_item rand_item();
        osg_pkg::t_in_item it;
        int                pick;
        it = '0;
        it.front_distance = 16'(near_level());
        it.rear_distance = 16'(near_level());
        it.beam_angle = ($urandom_range(99) < 85) ? 9'($urandom_range(0, 359))
                                                  : 9'($urandom_range(360, 511));
        it.beam_range_cm = ($urandom_range(99) < 70) ? 12'($urandom_range(0, 160))
                                                     : 12'($urandom_range(0, 4095));
        it.beam_valid = $urandom_range(99) < 90;
        it.scan_end = $urandom_range(7) == 0;
        it.park_on = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 28) begin
            it.command = osg_pkg::CMD_ULTRA;
        end else if (pick < 68) begin
            it.command = osg_pkg::CMD_LIDAR;
        end else if (pick < 74) begin
            it.command = osg_pkg::CMD_PARK;
        end else begin
            it.command = osg_pkg::CMD_TICK;
        end
        return it;
    endfunction

    task automatic put_item(osg_pkg::t_in_item it, bit typed, osg_pkg::t_out_item want);
        t_tag tag;
        while (!calm && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        tag.typed = typed;
        tag.want = want;
        tag_q.insert(tag_q.size(), tag);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [osg_pkg::CFG_IDX_W-1:0] idx,
                             logic [osg_pkg::CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(int ps, int st, int sl, int fs, int cf, int lo, int hi);
        write_reg(osg_pkg::CFG_PARK_STOP, 15'(ps));
        write_reg(osg_pkg::CFG_STOP, 15'(st));
        write_reg(osg_pkg::CFG_SLOW, 15'(sl));
        write_reg(osg_pkg::CFG_FIRST_SLOW, 15'(fs));
        write_reg(osg_pkg::CFG_CAREFUL, 15'(cf));
        write_reg(osg_pkg::CFG_LIDAR_MIN, 15'(lo));
        write_reg(osg_pkg::CFG_LIDAR_MAX, 15'(hi));
    endtask

    task automatic run_random(int n, int calm_count);
        for (int i = 0; i < n; i++) begin
            calm = (i < calm_count);
            put_item(rand_item(), 1'b0, '0);
        end
        calm = 1'b0;
    endtask

    initial begin
        add_row(tick_item(), 0, '0);
        add_row(item_of(osg_pkg::CMD_ULTRA, -32768, 32767, 0, 0, 0, 0, 0), 0, '0);
        add_row(tick_item(), 1, want_of(osg_pkg::SPD_STOP, osg_pkg::SPD_CLEAR, 0, 0));
        add_row(item_of(osg_pkg::CMD_ULTRA, 30, 69, 0, 0, 0, 0, 0), 0, '0);
        add_row(tick_item(), 1, want_of(osg_pkg::SPD_WALK, osg_pkg::SPD_HALF, 0, 0));
        // careful band leaves nothing to publish
        add_row(item_of(osg_pkg::CMD_ULTRA, 70, 99, 0, 0, 0, 0, 0), 0, '0);
        add_row(tick_item(), 0, '0);
        add_row(item_of(osg_pkg::CMD_ULTRA, 100, 70, 0, 0, 0, 0, 0), 0, '0);
        add_row(tick_item(), 1, want_of(osg_pkg::SPD_CLEAR, osg_pkg::SPD_DETECTED, 0, 0));
        add_row(tick_item(), 0, '0);
        // angle past the table wraps to 90 degrees: back zone
        add_row(item_of(osg_pkg::CMD_LIDAR, 0, 0, 450, 20, 1, 1, 0), 0, '0);
        add_row(item_of(osg_pkg::CMD_PARK, 0, 0, 0, 0, 0, 0, 1), 0, '0);
        add_row(item_of(osg_pkg::CMD_ULTRA, 500, 16, 0, 0, 0, 0, 0), 0, '0);
        add_row(tick_item(), 1, want_of(osg_pkg::SPD_CLEAR, osg_pkg::SPD_STOP, 0, 1));
        // invalid beam still closes the scan
        add_row(item_of(osg_pkg::CMD_LIDAR, 0, 0, 270, 80, 1, 0, 0), 0, '0);
        add_row(item_of(osg_pkg::CMD_LIDAR, 0, 0, 0, 4095, 0, 1, 0), 0, '0);
        add_row(item_of(osg_pkg::CMD_ULTRA, 1000, 2000, 0, 0, 0, 0, 0), 0, '0);
        add_row(tick_item(), 1, want_of(osg_pkg::SPD_STOP, osg_pkg::SPD_STOP, 1, 0));
        // point on y = 0 lands in both zones
        add_row(item_of(osg_pkg::CMD_LIDAR, 0, 0, 270, 40, 1, 1, 0), 0, '0);
        add_row(item_of(osg_pkg::CMD_ULTRA, 300, 300, 0, 0, 0, 0, 0), 0, '0);
        add_row(tick_item(), 1, want_of(osg_pkg::SPD_STOP, osg_pkg::SPD_STOP, 1, 1));
        add_row(item_of(osg_pkg::CMD_LIDAR, 0, 0, 270, 12, 1, 1, 0), 0, '0);
        add_row(item_of(osg_pkg::CMD_ULTRA, 300, 300, 0, 0, 0, 0, 0), 0, '0);
        add_row(tick_item(), 1, want_of(osg_pkg::SPD_CLEAR, osg_pkg::SPD_CLEAR, 0, 0));
        add_row(item_of(osg_pkg::CMD_PARK, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(item_of(osg_pkg::CMD_ULTRA, 32767, -1, 0, 0, 0, 0, 0), 0, '0);
        add_row(tick_item(), 1, want_of(osg_pkg::SPD_CLEAR, osg_pkg::SPD_STOP, 0, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            put_item(rows[i].item, rows[i].typed, rows[i].want);
        end
        settle();

        write_all($urandom_range(0, 60), $urandom_range(10, 60), $urandom_range(40, 120),
                  $urandom_range(80, 200), $urandom_range(150, 300),
                  $urandom_range(0, 30), $urandom_range(200, 4095));
        run_random(260, 150);
        settle();

        // all levels at zero, widest lidar window (upper data bits dropped)
        write_all(0, 0, 0, 0, 0, 0, 15'h7fff);
        run_random(250, 0);
        settle();

        // all levels at top, lidar window closed
        write_all(15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 0);
        run_random(250, 0);
        settle();

        write_all($urandom_range(0, 300), $urandom_range(0, 300), $urandom_range(0, 300),
                  $urandom_range(0, 300), $urandom_range(0, 300),
                  $urandom_range(0, 4095), $urandom_range(0, 4095));
        write_reg(CFG_UNUSED_IDX, 15'($urandom));
        run_random(270, 0);
        settle();

        $display("covered %0d transactions in, %0d reports checked, %0d register writes",
                 n_items, n_reports, n_writes);
        $display("phases: directed table, sane levels, zero levels, top levels, scrambled");
        if (n_errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
